FILE: hdl/gpsg_pkg.sv
// Shared constants, configuration struct and helper functions for the
// gain / high-pass / shelf / gate unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpsg_pkg;

  localparam int MAX_STAGES = 4;
  localparam int COEF_F     = 16;
  localparam int STG_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 7;
  localparam int ALPHA_W    = COEF_F;
  localparam int SHELF_W    = COEF_F + 1;
  localparam int CNT_W      = 3;
  localparam int THR_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int SCALED_W   = SAMPLE_W + GAIN_W + 1;
  localparam int HIST_W     = 32;
  localparam int ENTRY_W    = 2 * HIST_W;
  localparam int DIFF_W     = HIST_W + 2;
  localparam int CHUNK_W    = DIFF_W / 2;
  localparam int OPD_W      = CHUNK_W + 1;
  localparam int COEF_W     = COEF_F + 1;
  localparam int PROD_W     = COEF_W + 1 + OPD_W;
  localparam int SUM_W      = PROD_W + CHUNK_W + 1;
  localparam int QUO_W      = SUM_W - COEF_F;
  localparam int Z_W        = QUO_W + 1;
  localparam int RES_W      = Z_W - 8;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GATE   = 3'd4;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [ALPHA_W-1:0] alpha;
    logic [STG_W-1:0]   last_stage;
    logic [SHELF_W-1:0] shelf;
    logic [THR_W-1:0]   gate_thr;
  } cfg_t;

  function automatic logic [STG_W-1:0] last_stage_of(input logic [CNT_W-1:0] cnt);
    logic [STG_W-1:0] r;
    if (cnt == '0) begin
      r = '0;
    end else if (int'(cnt) > MAX_STAGES) begin
      r = STG_W'(MAX_STAGES - 1);
    end else begin
      r = STG_W'(cnt - CNT_W'(1));
    end
    return r;
  endfunction

  function automatic logic [SHELF_W-1:0] shelf_clamp(input logic [SHELF_W-1:0] v);
    logic [SHELF_W-1:0] one;
    one = SHELF_W'(1) << COEF_F;
    return (v > one) ? one : v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gpsg_hist_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered
// read port. Holds the per-stage filter history. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gpsg_hist_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gpsg_mul.sv
// Shared registered multiplier: unsigned coefficient times one signed
// chunk of a difference. Uses gpsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpsg_mul (
  input  wire logic                                clk,
  input  wire logic        [gpsg_pkg::COEF_W-1:0]  coef,
  input  wire logic signed [gpsg_pkg::OPD_W-1:0]   opd,
  output logic signed      [gpsg_pkg::PROD_W-1:0]  prod_r
);

  logic signed [gpsg_pkg::COEF_W:0]   coef_s;
  logic signed [gpsg_pkg::PROD_W-1:0] prod_nxt;

  assign coef_s   = $signed({1'b0, coef});
  assign prod_nxt = coef_s * opd;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/gpsg_core.sv
// Sequencer and datapath: gain, per-stage read-modify-write of history,
// shelf blend, saturation, gate and output register. Uses gpsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpsg_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire gpsg_pkg::cfg_t                        cfg,
  input  wire logic                                  hist_clr,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [gpsg_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  wire logic                                  in_block_end,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [gpsg_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                       out_block_end_out,
  output logic                                       mem_rd_en,
  output logic             [gpsg_pkg::STG_W-1:0]     mem_rd_addr,
  input  wire logic        [gpsg_pkg::ENTRY_W-1:0]   mem_rd_data,
  output logic                                       mem_wr_en,
  output logic             [gpsg_pkg::STG_W-1:0]     mem_wr_addr,
  output logic             [gpsg_pkg::ENTRY_W-1:0]   mem_wr_data,
  output logic             [gpsg_pkg::COEF_W-1:0]    mul_coef,
  output logic signed      [gpsg_pkg::OPD_W-1:0]     mul_opd,
  input  wire logic signed [gpsg_pkg::PROD_W-1:0]    mul_prod
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MLO,
    S_MHI,
    S_RND,
    S_OUT
  } state_t;

  localparam logic signed [gpsg_pkg::SUM_W-1:0] HALF =
    gpsg_pkg::SUM_W'(1) <<< (gpsg_pkg::COEF_F - 1);

  state_t                                       state_r;
  logic                                         shelf_r;
  logic        [gpsg_pkg::STG_W-1:0]            k_r;
  logic signed [gpsg_pkg::HIST_W-1:0]           x_r;
  logic signed [gpsg_pkg::HIST_W-1:0]           y_r;
  logic signed [gpsg_pkg::DIFF_W-1:0]           d_r;
  logic signed [gpsg_pkg::PROD_W-1:0]           plo_r;
  logic signed [gpsg_pkg::RES_W-1:0]            res_r;
  logic                                         blk_r;
  logic        [gpsg_pkg::MAX_STAGES-1:0]       vld_r;
  logic                                         rd_vld_r;
  logic                                         out_valid_r;
  logic signed [gpsg_pkg::SAMPLE_W-1:0]         out_sample_r;
  logic                                         out_blk_r;

  logic                                         in_acc;
  logic signed [gpsg_pkg::SCALED_W-1:0]         s_nxt;
  logic signed [gpsg_pkg::HIST_W-1:0]           x_nxt;
  logic signed [gpsg_pkg::HIST_W-1:0]           h_in;
  logic signed [gpsg_pkg::HIST_W-1:0]           h_out;
  logic signed [gpsg_pkg::DIFF_W-1:0]           d_nxt;
  logic signed [gpsg_pkg::CHUNK_W-1:0]          d_hi;
  logic signed [gpsg_pkg::SUM_W-1:0]            p_sum;
  logic signed [gpsg_pkg::SUM_W-1:0]            p_rnd;
  logic signed [gpsg_pkg::QUO_W-1:0]            q;
  logic signed [gpsg_pkg::HIST_W-1:0]           o_sat;
  logic signed [gpsg_pkg::Z_W-1:0]              z;
  logic signed [gpsg_pkg::Z_W-1:0]              z_adj;
  logic signed [gpsg_pkg::RES_W-1:0]            z_int;
  logic signed [gpsg_pkg::SAMPLE_W-1:0]         s16;
  logic        [gpsg_pkg::SAMPLE_W:0]           mag;
  logic signed [gpsg_pkg::SAMPLE_W-1:0]         gated;
  logic                                         last_stage;
  logic                                         out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_block_end_out = out_blk_r;

  assign s_nxt = in_sample_in * $signed({1'b0, cfg.gain});
  assign x_nxt = {s_nxt, 8'b0};

  assign h_in  = rd_vld_r ? $signed(mem_rd_data[gpsg_pkg::ENTRY_W-1:gpsg_pkg::HIST_W]) : '0;
  assign h_out = rd_vld_r ? $signed(mem_rd_data[gpsg_pkg::HIST_W-1:0]) : '0;
  assign d_nxt = shelf_r
    ? gpsg_pkg::DIFF_W'(x_r) - gpsg_pkg::DIFF_W'(y_r)
    : gpsg_pkg::DIFF_W'(h_out) + gpsg_pkg::DIFF_W'(y_r) - gpsg_pkg::DIFF_W'(h_in);

  assign d_hi     = d_r[gpsg_pkg::DIFF_W-1:gpsg_pkg::CHUNK_W];
  assign mul_coef = shelf_r ? cfg.shelf : gpsg_pkg::COEF_W'(cfg.alpha);
  assign mul_opd  = (state_r == S_MLO) ? $signed({1'b0, d_r[gpsg_pkg::CHUNK_W-1:0]})
                                       : gpsg_pkg::OPD_W'(d_hi);

  // round to nearest, ties away from zero, then drop the fraction
  assign p_sum = (gpsg_pkg::SUM_W'(mul_prod) <<< gpsg_pkg::CHUNK_W) + gpsg_pkg::SUM_W'(plo_r);
  assign p_rnd = p_sum + HALF - $signed({{(gpsg_pkg::SUM_W-1){1'b0}}, p_sum[gpsg_pkg::SUM_W-1]});
  assign q     = gpsg_pkg::QUO_W'(p_rnd >>> gpsg_pkg::COEF_F);

  always_comb begin
    if (q[gpsg_pkg::QUO_W-1:gpsg_pkg::HIST_W-1] == '0 ||
        q[gpsg_pkg::QUO_W-1:gpsg_pkg::HIST_W-1] == '1) begin
      o_sat = q[gpsg_pkg::HIST_W-1:0];
    end else begin
      o_sat = q[gpsg_pkg::QUO_W-1] ? {1'b1, {(gpsg_pkg::HIST_W-1){1'b0}}}
                                   : {1'b0, {(gpsg_pkg::HIST_W-1){1'b1}}};
    end
  end

  assign z     = gpsg_pkg::Z_W'(y_r) + gpsg_pkg::Z_W'(q);
  assign z_adj = z + (z[gpsg_pkg::Z_W-1] ? gpsg_pkg::Z_W'(255) : gpsg_pkg::Z_W'(0));
  assign z_int = gpsg_pkg::RES_W'(z_adj >>> 8);

  always_comb begin
    if (res_r[gpsg_pkg::RES_W-1:gpsg_pkg::SAMPLE_W-1] == '0 ||
        res_r[gpsg_pkg::RES_W-1:gpsg_pkg::SAMPLE_W-1] == '1) begin
      s16 = res_r[gpsg_pkg::SAMPLE_W-1:0];
    end else begin
      s16 = res_r[gpsg_pkg::RES_W-1] ? {1'b1, {(gpsg_pkg::SAMPLE_W-1){1'b0}}}
                                     : {1'b0, {(gpsg_pkg::SAMPLE_W-1){1'b1}}};
    end
    mag   = s16[gpsg_pkg::SAMPLE_W-1] ? -{1'b1, s16} : {1'b0, s16};
    gated = (cfg.gate_thr != '0 && mag < (gpsg_pkg::SAMPLE_W+1)'(cfg.gate_thr)) ? '0 : s16;
  end

  assign last_stage = (k_r == cfg.last_stage);
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign mem_rd_en   = in_acc || (state_r == S_RND && !shelf_r && !last_stage);
  assign mem_rd_addr = in_acc ? '0 : k_r + gpsg_pkg::STG_W'(1);
  assign mem_wr_en   = (state_r == S_RND) && !shelf_r;
  assign mem_wr_addr = k_r;
  assign mem_wr_data = {y_r, o_sat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shelf_r     <= 1'b0;
      k_r         <= '0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (hist_clr) begin
        vld_r <= '0;
      end else if (mem_wr_en) begin
        vld_r[mem_wr_addr] <= 1'b1;
      end
      if (mem_rd_en) begin
        rd_vld_r <= vld_r[mem_rd_addr];
      end
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= gated;
        out_blk_r    <= blk_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r     <= x_nxt;
            y_r     <= x_nxt;
            res_r   <= gpsg_pkg::RES_W'(s_nxt);
            blk_r   <= in_block_end;
            k_r     <= '0;
            shelf_r <= 1'b0;
            state_r <= (cfg.alpha == '0) ? S_OUT : S_DIFF;
          end
        end
        S_DIFF: begin
          d_r     <= d_nxt;
          state_r <= S_MLO;
        end
        S_MLO: begin
          state_r <= S_MHI;
        end
        S_MHI: begin
          plo_r   <= mul_prod;
          state_r <= S_RND;
        end
        S_RND: begin
          if (shelf_r) begin
            res_r   <= z_int;
            state_r <= S_OUT;
          end else begin
            y_r     <= o_sat;
            state_r <= S_DIFF;
            if (last_stage) begin
              shelf_r <= 1'b1;
            end else begin
              k_r <= k_r + gpsg_pkg::STG_W'(1);
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gain_highpass_shelf_gate_unit.sv
// Top level: configuration registers, sequencer core, history RAM and
// shared multiplier. Uses gpsg_pkg, gpsg_core, gpsg_hist_ram, gpsg_mul.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   in_sample_in, in_block_end
//   out_     output     out_valid/out_ready out_sample_out, out_block_end_out
//   cfg_     input      cfg_write_en        cfg_index, cfg_data
//
// One sample at a time. With the high-pass coefficient non-zero each of the N
// stages in use reads its history entry, forms the difference and passes two halves
// through the shared 18x18 multiplier before rounding and write-back; the shelf
// blend uses the same path once more. With the coefficient zero a sample goes
// straight to the output state.
// Synchronous reset clears control state and the history valid bits; there
// is no clearing pass. A waiting result in the output register holds the
// core in its final state but not the next acceptance before that.
`timescale 1ns / 1ps
`default_nettype none

module gain_highpass_shelf_gate_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [gpsg_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  wire logic                                  in_block_end,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [gpsg_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                       out_block_end_out,
  input  wire logic                                  cfg_write_en,
  input  wire logic        [gpsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [gpsg_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [gpsg_pkg::GAIN_W-1:0]  gain_r;
  logic [gpsg_pkg::ALPHA_W-1:0] alpha_r;
  logic [gpsg_pkg::CNT_W-1:0]   stages_r;
  logic [gpsg_pkg::SHELF_W-1:0] shelf_r;
  logic [gpsg_pkg::THR_W-1:0]   gate_r;

  gpsg_pkg::cfg_t                        cfg;
  logic                                  hist_clr;
  logic                                  mem_rd_en;
  logic [gpsg_pkg::STG_W-1:0]            mem_rd_addr;
  logic [gpsg_pkg::ENTRY_W-1:0]          mem_rd_data;
  logic                                  mem_wr_en;
  logic [gpsg_pkg::STG_W-1:0]            mem_wr_addr;
  logic [gpsg_pkg::ENTRY_W-1:0]          mem_wr_data;
  logic [gpsg_pkg::COEF_W-1:0]           mul_coef;
  logic signed [gpsg_pkg::OPD_W-1:0]     mul_opd;
  logic signed [gpsg_pkg::PROD_W-1:0]    mul_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= gpsg_pkg::GAIN_W'(1);
      alpha_r  <= '0;
      stages_r <= gpsg_pkg::CNT_W'(1);
      shelf_r  <= '0;
      gate_r   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        gpsg_pkg::REG_GAIN:   gain_r   <= cfg_data[gpsg_pkg::GAIN_W-1:0];
        gpsg_pkg::REG_ALPHA:  alpha_r  <= cfg_data[gpsg_pkg::ALPHA_W-1:0];
        gpsg_pkg::REG_STAGES: stages_r <= cfg_data[gpsg_pkg::CNT_W-1:0];
        gpsg_pkg::REG_SHELF:  shelf_r  <= cfg_data[gpsg_pkg::SHELF_W-1:0];
        gpsg_pkg::REG_GATE:   gate_r   <= cfg_data[gpsg_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // any filter register write drops all stage history
  assign hist_clr = cfg_write_en && (cfg_index == gpsg_pkg::REG_ALPHA ||
                                     cfg_index == gpsg_pkg::REG_STAGES ||
                                     cfg_index == gpsg_pkg::REG_SHELF);

  always_comb begin
    cfg.gain       = gain_r;
    cfg.alpha      = alpha_r;
    cfg.last_stage = gpsg_pkg::last_stage_of(stages_r);
    cfg.shelf      = gpsg_pkg::shelf_clamp(shelf_r);
    cfg.gate_thr   = gate_r;
  end

  gpsg_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .hist_clr          (hist_clr),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_in      (in_sample_in),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_block_end_out (out_block_end_out),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data),
    .mul_coef          (mul_coef),
    .mul_opd           (mul_opd),
    .mul_prod          (mul_prod)
  );

  gpsg_hist_ram #(
    .WIDTH (gpsg_pkg::ENTRY_W),
    .DEPTH (gpsg_pkg::MAX_STAGES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  gpsg_mul u_mul (
    .clk    (clk),
    .coef   (mul_coef),
    .opd    (mul_opd),
    .prod_r (mul_prod)
  );

endmodule

`default_nettype wire

FILE: hdl/gpsg_checker.sv
// Port-level checker for gain_highpass_shelf_gate_unit, bound to the top
// level. Uses gpsg_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module gpsg_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic signed [gpsg_pkg::SAMPLE_W-1:0]  out_sample_out,
  input wire logic                                  out_block_end_out
);

  logic [1:0] cnt_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) &&
                                $stable(out_block_end_out))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> cnt_r != 2'd0)
    else $error("result without request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> cnt_r == 2'd0 || cnt_r == 2'd1)
    else $error("more than two requests outstanding");

endmodule

bind gain_highpass_shelf_gate_unit gpsg_checker u_gpsg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sample_out    (out_sample_out),
  .out_block_end_out (out_block_end_out)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking bench for gain_highpass_shelf_gate_unit: random and directed samples
// through gain, cascaded high-pass, shelf blend, saturation and gate, checked by a predictor.
// Depends on gpsg_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int DIRECTED_ITEMS = 21;
  localparam int RANDOM_ITEMS   = 1779;
  localparam logic [4:0][gpsg_pkg::CFG_IDX_W-1:0] REG_ORDER =
    {gpsg_pkg::REG_GATE, gpsg_pkg::REG_SHELF, gpsg_pkg::REG_STAGES,
     gpsg_pkg::REG_ALPHA, gpsg_pkg::REG_GAIN};

  typedef logic [4:0][gpsg_pkg::CFG_DATA_W-1:0] settings_t;

  typedef struct packed {
    logic signed [gpsg_pkg::SAMPLE_W-1:0] sample;
    logic                                 block_end;
  } gated_sample_t;

  class gate_unit_tracker;
    localparam longint HIST_MAX = (longint'(1) << (gpsg_pkg::HIST_W - 1)) - 1;
    localparam longint HIST_MIN = -(longint'(1) << (gpsg_pkg::HIST_W - 1));

    logic [gpsg_pkg::GAIN_W-1:0]        gain;
    logic [gpsg_pkg::ALPHA_W-1:0]       alpha;
    logic [gpsg_pkg::CNT_W-1:0]         stages;
    logic [gpsg_pkg::SHELF_W-1:0]       shelf;
    logic [gpsg_pkg::THR_W-1:0]         gate_thr;
    logic signed [gpsg_pkg::HIST_W-1:0] in_hist [gpsg_pkg::MAX_STAGES];
    logic signed [gpsg_pkg::HIST_W-1:0] out_hist [gpsg_pkg::MAX_STAGES];
    gated_sample_t                      awaited_samples [$];
    int                                 mismatches;
    int                                 checked;

    function new();
      gain = gpsg_pkg::GAIN_W'(1);
      alpha = '0;
      stages = gpsg_pkg::CNT_W'(1);
      shelf = '0;
      gate_thr = '0;
      mismatches = 0;
      checked = 0;
      clear_history();
    endfunction

    function void clear_history();
      for (int k = 0; k < gpsg_pkg::MAX_STAGES; k++) begin
        in_hist[k] = '0;
        out_hist[k] = '0;
      end
    endfunction

    function void set_reg(logic [gpsg_pkg::CFG_IDX_W-1:0] idx,
                          logic [gpsg_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gpsg_pkg::REG_GAIN: gain = data[gpsg_pkg::GAIN_W-1:0];
        gpsg_pkg::REG_ALPHA: begin
          alpha = data[gpsg_pkg::ALPHA_W-1:0];
          clear_history();
        end
        gpsg_pkg::REG_STAGES: begin
          stages = data[gpsg_pkg::CNT_W-1:0];
          clear_history();
        end
        gpsg_pkg::REG_SHELF: begin
          shelf = data[gpsg_pkg::SHELF_W-1:0];
          clear_history();
        end
        gpsg_pkg::REG_GATE: gate_thr = data[gpsg_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function longint round_coef(longint coef, longint v);
      longint p;
      p = coef * v;
      if (p < 0) begin
        p = p - (longint'(1) << (gpsg_pkg::COEF_F - 1));
      end else begin
        p = p + (longint'(1) << (gpsg_pkg::COEF_F - 1));
      end
      return p / (longint'(1) << gpsg_pkg::COEF_F);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function logic signed [gpsg_pkg::SAMPLE_W-1:0] predict_filtered(
        logic signed [gpsg_pkg::SAMPLE_W-1:0] x16);
      longint s, x, y, d, z, sh, mag;
      int     n;
      s = longint'(x16) * longint'(gain);
      if (alpha != '0) begin
        n = int'(stages);
        if (n < 1) n = 1;
        if (n > gpsg_pkg::MAX_STAGES) n = gpsg_pkg::MAX_STAGES;
        sh = longint'(shelf);
        if (sh > (longint'(1) << gpsg_pkg::COEF_F)) sh = longint'(1) << gpsg_pkg::COEF_F;
        x = s * 256;
        y = x;
        for (int k = 0; k < n; k++) begin
          d = longint'(out_hist[k]) + y - longint'(in_hist[k]);
          in_hist[k] = gpsg_pkg::HIST_W'(y);
          y = clamp(round_coef(longint'(alpha), d), HIST_MIN, HIST_MAX);
          out_hist[k] = gpsg_pkg::HIST_W'(y);
        end
        z = y + round_coef(sh, x - y);
        s = z / 256;
      end
      s = clamp(s, -32768, 32767);
      if (gate_thr != '0) begin
        mag = (s < 0) ? -s : s;
        if (mag < longint'(gate_thr)) s = 0;
      end
      return gpsg_pkg::SAMPLE_W'(s);
    endfunction

    function void note_request(logic signed [gpsg_pkg::SAMPLE_W-1:0] sample, logic blk);
      gated_sample_t e;
      e.sample = predict_filtered(sample);
      e.block_end = blk;
      awaited_samples.push_back(e);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_sample(logic signed [gpsg_pkg::SAMPLE_W-1:0] sample, logic blk);
      gated_sample_t e;
      if (awaited_samples.size() == 0) begin
        report_mismatch($sformatf("result %0d with no sample outstanding", sample));
        return;
      end
      e = awaited_samples.pop_front();
      checked++;
      if (sample !== e.sample)
        report_mismatch($sformatf("result %0d: sample_out %0d, predicted %0d",
                                  checked, sample, e.sample));
      if (blk !== e.block_end)
        report_mismatch($sformatf("result %0d: block_end_out %b, predicted %b",
                                  checked, blk, e.block_end));
    endtask

    function int pending();
      return awaited_samples.size();
    endfunction
  endclass

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_ready;
  logic signed [gpsg_pkg::SAMPLE_W-1:0]  in_sample_in;
  logic                                  in_block_end;
  logic                                  out_valid;
  logic                                  out_ready;
  logic signed [gpsg_pkg::SAMPLE_W-1:0]  out_sample_out;
  logic                                  out_block_end_out;
  logic                                  cfg_write_en;
  logic [gpsg_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [gpsg_pkg::CFG_DATA_W-1:0]       cfg_data;

  gate_unit_tracker tracker = new();
  int tx_max_gap;
  int rx_max_stall;
  int sent_items;
  int settings_count;
  int idle_cycles;

  gain_highpass_shelf_gate_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_in      (in_sample_in),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_block_end_out (out_block_end_out),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_request(in_sample_in, in_block_end);
      if (out_valid && out_ready) tracker.check_sample(out_sample_out, out_block_end_out);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(rx_max_stall, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input logic signed [gpsg_pkg::SAMPLE_W-1:0] s, input logic b);
    int gap;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    in_block_end <= b;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_settings(input settings_t vals, input logic [4:0] mask,
                                  input bit stray);
    logic [gpsg_pkg::CFG_IDX_W-1:0]  idx;
    logic [gpsg_pkg::CFG_DATA_W-1:0] data;
    for (int i = 0; i < 5; i++) begin
      if (mask[i]) begin
        cfg_write_en <= 1'b1;
        cfg_index <= REG_ORDER[i];
        cfg_data <= vals[i];
        tracker.set_reg(REG_ORDER[i], vals[i]);
        @(posedge clk);
      end
    end
    if (stray) begin
      idx = gpsg_pkg::CFG_IDX_W'($urandom_range((1 << gpsg_pkg::CFG_IDX_W) - 1,
                                                int'(gpsg_pkg::REG_GATE) + 1));
      data = gpsg_pkg::CFG_DATA_W'($urandom);
      cfg_write_en <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      tracker.set_reg(idx, data);
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
    settings_count++;
  endtask

  function automatic settings_t settings_of(int g, int a, int n, int s, int t);
    return {gpsg_pkg::CFG_DATA_W'(t), gpsg_pkg::CFG_DATA_W'(s), gpsg_pkg::CFG_DATA_W'(n),
            gpsg_pkg::CFG_DATA_W'(a), gpsg_pkg::CFG_DATA_W'(g)};
  endfunction

  function automatic settings_t pick_settings();
    int g, a, n, s, t;
    case ($urandom_range(0, 4))
      0: g = 0;
      1: g = 1;
      2: g = 64;
      3: g = 127;
      default: g = $urandom_range(0, 64);
    endcase
    case ($urandom_range(0, 5))
      0: a = 0;
      1: a = 65535;
      2: a = 1;
      default: a = $urandom_range(1, 65535);
    endcase
    n = $urandom_range(0, 7);
    case ($urandom_range(0, 4))
      0: s = 0;
      1: s = 65536;
      2: s = 131071;
      default: s = $urandom_range(0, 65536);
    endcase
    case ($urandom_range(0, 5))
      3: t = 32767;
      4: t = $urandom_range(1, 3000);
      5: t = $urandom_range(1, 32767);
      default: t = 0;
    endcase
    return settings_of(g, a, n, s, t);
  endfunction

  function automatic logic signed [gpsg_pkg::SAMPLE_W-1:0] pick_sample();
    logic signed [gpsg_pkg::SAMPLE_W-1:0] extremes [5] =
      '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1};
    case ($urandom_range(0, 7))
      0: return extremes[$urandom_range(0, 4)];
      1, 2: return gpsg_pkg::SAMPLE_W'($urandom_range(0, 600) - 300);
      default: return gpsg_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    bit first_phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    in_block_end = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent_items = 0;
    settings_count = 0;
    tx_max_gap = 19;
    rx_max_stall = 19;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gain of one, filter bypassed, gate off
    send_request(16'sd32767, 1'b0);
    send_request(-16'sd32768, 1'b1);
    send_request(16'sd0, 1'b0);
    send_request(-16'sd1, 1'b1);
    send_request(16'sd1, 1'b0);

    // gain at its top, zero stage count, shelf above one
    drain_and_settle();
    program_settings(settings_of(127, 65535, 0, 131071, 0), 5'b11111, 1'b1);
    send_request(16'sd32767, 1'b1);
    send_request(-16'sd32768, 1'b0);
    send_request(16'sd12345, 1'b0);

    // stage count above the maximum, smallest non-zero alpha, gate at its top
    drain_and_settle();
    program_settings(settings_of(64, 1, 7, 0, 32767), 5'b11111, 1'b0);
    send_request(-16'sd32768, 1'b0);
    send_request(16'sd32767, 1'b1);
    send_request(-16'sd1, 1'b0);
    send_request(16'sd100, 1'b0);

    // full cascade with shelf of exactly one, gate at one
    drain_and_settle();
    program_settings(settings_of(64, 65535, 4, 65536, 1), 5'b11111, 1'b0);
    send_request(16'sd0, 1'b0);
    send_request(16'sd32767, 1'b0);
    send_request(16'sd32767, 1'b1);
    send_request(-16'sd32768, 1'b0);
    send_request(-16'sd32768, 1'b0);

    // rewrite alpha unchanged: history must clear
    drain_and_settle();
    program_settings(settings_of(64, 65535, 4, 65536, 1), 5'b00010, 1'b0);
    send_request(16'sd32767, 1'b0);
    send_request(-16'sd32768, 1'b1);

    // zero gain, gate off
    drain_and_settle();
    program_settings(settings_of(0, 65535, 4, 65536, 0), 5'b10001, 1'b0);
    send_request(16'sd32767, 1'b0);
    send_request(-16'sd32768, 1'b1);

    first_phase = 1'b1;
    while (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      drain_and_settle();
      program_settings(pick_settings(), first_phase ? 5'b11111 : 5'($urandom_range(0, 31)),
                       $urandom_range(0, 3) == 0);
      first_phase = 1'b0;
      tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
      rx_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 19;
      burst = $urandom_range(20, 120);
      if (burst > DIRECTED_ITEMS + RANDOM_ITEMS - sent_items)
        burst = DIRECTED_ITEMS + RANDOM_ITEMS - sent_items;
      repeat (burst) send_request(pick_sample(), $urandom_range(0, 7) == 0);
    end

    drain_and_settle();
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
    $display("summary: %0d samples sent, %0d results compared, %0d register settings",
             sent_items, tracker.checked, settings_count);
    $display("summary: %0d mismatches", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
